>>> hw/rtl/tllmp_pkg.sv
// ----------------------------------------------------------------------------
// tllmp_pkg: shared types and constants of the lookup mode predictor
// history length, counter table geometry, event codes, counter training
// ----------------------------------------------------------------------------
package tllmp_pkg;

    localparam int HISTORY_BITS = 9;
    localparam int TABLE_DEPTH  = 1 << HISTORY_BITS;
    localparam int CNT_BITS     = 2;
    localparam int COUNT_BITS   = 32;
    localparam int SIZE_BITS    = 32;
    localparam int OFFSET_BITS  = 16;

    localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 16'd5000;

    typedef logic [HISTORY_BITS-1:0] hist_t;
    typedef logic [CNT_BITS-1:0]     pcnt_t;
    typedef logic [1:0]              op_t;

    localparam op_t OP_HASH    = 2'd0;
    localparam op_t OP_BSEARCH = 2'd1;
    localparam op_t OP_CHANGE  = 2'd2;

    // 2-bit saturating counter: step down when not worthy, up when worthy
    function automatic pcnt_t train_counter(input pcnt_t cur, input logic worthy);
        pcnt_t res;
        if (worthy)
        begin
            res = (cur == 2'd3) ? cur : cur + 2'd1;
        end
        else
        begin
            res = (cur == 2'd0) ? cur : cur - 2'd1;
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/tllmp_ram.sv
// ----------------------------------------------------------------------------
// tllmp_ram: generic simple dual-port ram
// one write port, one read port, registered read data (old data on collision)
// ----------------------------------------------------------------------------
module tllmp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/two_level_lookup_mode_predictor.sv
// ----------------------------------------------------------------------------
// two_level_lookup_mode_predictor: hash vs binary search mode predictor
// global-history two-level predictor with a ram of 2-bit counters
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready, op, set_size) carries one event per
//   transfer: hashed lookup, binary-search lookup, or set changed
//   output channel (out_valid/out_ready, use_hash) returns exactly one
//   result per event, in order
//   cfg_we/cfg_wdata write worth_offset; the user must write it only while idle, the block does not enforce it
// sequencing
//   hashed lookup: result registered at the accepting edge, one event per cycle unless the output stalls
//   binary-search lookup: n+offset is registered, then the threshold 3*(n+offset)
//     is formed and compared in ST_LIMIT
//   set change: sequenced by the single read port of the counter ram
//     (read old entry, write trained entry and read new entry, select)
// reset
//   all control state clears at once; then a clearing pass writes zero to
//   all 512 counters, one per cycle, with in_ready low
// stall
//   a held result sits in the output register; a new event is taken only
//   when that register is free or being drained in the same cycle
// ----------------------------------------------------------------------------
module two_level_lookup_mode_predictor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tllmp_pkg::OFFSET_BITS-1:0] cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     op,
    input  logic [tllmp_pkg::SIZE_BITS-1:0] set_size,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           use_hash
);
    import tllmp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LIMIT,
        ST_RD1,
        ST_RD2
    } state_t;

    state_t                 state_reg, state_next;
    logic                   clr_busy_reg, clr_busy_next;
    hist_t                  clr_addr_reg, clr_addr_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    hist_t                  hist_reg, hist_next;
    hist_t                  old_addr_reg, old_addr_next;
    logic                   worthy_reg, worthy_next;
    pcnt_t                  trained_reg, trained_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [SIZE_BITS-1:0]   prior_reg, prior_next;
    logic [SIZE_BITS:0]     sum_reg, sum_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   use_hash_reg, use_hash_next;

    logic                   accept;
    logic                   out_free;
    logic [COUNT_BITS-1:0]  count_inc;
    logic [SIZE_BITS:0]     worth_limit;
    logic [SIZE_BITS+2:0]   bs_limit;
    logic                   worthy_now;
    pcnt_t                  trained;
    pcnt_t                  predict_cnt;

    logic                   ram_we;
    hist_t                  ram_waddr;
    pcnt_t                  ram_wdata;
    logic                   ram_re;
    pcnt_t                  ram_rdata;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = !clr_busy_reg && (state_reg == ST_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign use_hash  = use_hash_reg;

    // saturating lookup count
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    // run worthiness: count > prior size + offset, full width
    assign worth_limit = {1'b0, prior_reg} + {{(SIZE_BITS+1-OFFSET_BITS){1'b0}}, offset_reg};
    assign worthy_now  = {1'b0, count_reg} > worth_limit;

    // binary-search threshold 3*(n + offset) as sum + 2*sum
    assign bs_limit = {2'b00, sum_reg} + {1'b0, sum_reg, 1'b0};

    assign trained     = train_counter(ram_rdata, worthy_reg);
    // forward the freshly trained entry when new and old history match
    assign predict_cnt = (old_addr_reg == hist_reg) ? trained_reg : ram_rdata;

    // counter ram ports: clearing pass or training write, reads at history
    assign ram_we    = clr_busy_reg || (state_reg == ST_RD1);
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : old_addr_reg;
    assign ram_wdata = clr_busy_reg ? '0 : trained;
    assign ram_re    = (accept && (op == OP_CHANGE)) || (state_reg == ST_RD1);

    tllmp_ram #(
        .WIDTH (CNT_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_counters (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (hist_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_busy_next  = clr_busy_reg;
        clr_addr_next  = clr_addr_reg;
        offset_next    = cfg_we ? cfg_wdata : offset_reg;
        hist_next      = hist_reg;
        old_addr_next  = old_addr_reg;
        worthy_next    = worthy_reg;
        trained_next   = trained_reg;
        count_next     = count_reg;
        prior_next     = prior_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !out_ready;
        use_hash_next  = use_hash_reg;

        // clearing sweep after reset
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                clr_busy_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_HASH:
                        begin
                            count_next     = count_inc;
                            out_valid_next = 1'b1;
                            use_hash_next  = 1'b0;
                        end
                        OP_BSEARCH:
                        begin
                            count_next = count_inc;
                            sum_next   = {1'b0, set_size}
                                       + {{(SIZE_BITS+1-OFFSET_BITS){1'b0}}, offset_reg};
                            state_next = ST_LIMIT;
                        end
                        OP_CHANGE:
                        begin
                            worthy_next   = worthy_now;
                            old_addr_next = hist_reg;
                            hist_next     = hist_t'({hist_reg, worthy_now});
                            count_next    = COUNT_BITS'(1);
                            prior_next    = set_size;
                            state_next    = ST_RD1;
                        end
                        default:
                        begin
                            // unused code: no state change, result 0
                            out_valid_next = 1'b1;
                            use_hash_next  = 1'b0;
                        end
                    endcase
                end
            end
            ST_LIMIT:
            begin
                out_valid_next = 1'b1;
                use_hash_next  = {3'b000, count_reg} > bs_limit;
                state_next     = ST_IDLE;
            end
            ST_RD1:
            begin
                trained_next = trained;
                state_next   = ST_RD2;
            end
            ST_RD2:
            begin
                out_valid_next = 1'b1;
                use_hash_next  = predict_cnt[1];
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            offset_reg    <= OFFSET_RESET;
            hist_reg      <= '0;
            old_addr_reg  <= '0;
            worthy_reg    <= 1'b0;
            trained_reg   <= '0;
            count_reg     <= '0;
            prior_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            use_hash_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            offset_reg    <= offset_next;
            hist_reg      <= hist_next;
            old_addr_reg  <= old_addr_next;
            worthy_reg    <= worthy_next;
            trained_reg   <= trained_next;
            count_reg     <= count_next;
            prior_reg     <= prior_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            use_hash_reg  <= use_hash_next;
        end
    end

    // no event taken while the counter table is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !in_ready)
        else $error("input accepted during clearing pass");

    // the prediction select in ST_RD2 always follows the training step in ST_RD1
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD2) |-> $past(state_reg == ST_RD1))
        else $error("prediction read without training step");

    // a set change moves the history by exactly one judgement bit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD1) |-> (hist_reg == hist_t'({old_addr_reg, worthy_reg})))
        else $error("history shift mismatch");

    // a set change restarts the run count at one
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_CHANGE)) |=> (count_reg == COUNT_BITS'(1)))
        else $error("run count not restarted");

endmodule
